### rtl/core/modular_arithmetic_binomial_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular arithmetic binomial unit
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_BINOMIAL_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_BINOMIAL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define MAB_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define MAB_ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MAB_ASSERT(name, clk, rst, prop, msg)
`define MAB_ASSERT_NEVER(name, clk, rst, expr, msg)
`endif

`endif

### rtl/core/mab_pkg.sv
// ----------------------------------------------------------------------------
// mab_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mab_pkg;

  localparam int KIND_W = 3;
  localparam int OPND_W = 63;
  localparam int RES_W  = 30;
  localparam int K_W    = 17;
  localparam int SEL_W  = 3;
  localparam int ADD_W  = 34;

  localparam logic [RES_W-1:0] MODP    = 30'd1000000007;
  localparam logic [31:0]      MODP_X2 = 32'd2000000014;
  localparam logic [RES_W-1:0] EXP_E   = MODP - 30'd2;
  // Barrett constant floor(2^60 / MODP)
  localparam logic [30:0]      MU      = 31'((64'd1 << 60) / 64'(MODP));
  localparam logic [K_W-1:0]   MAX_K   = 17'd65536;
  // 2^30 and 2^60 modulo MODP, used to fold a 63-bit operand
  localparam logic [RES_W-1:0] FOLD_C  = 30'((64'd1 << 30) % 64'(MODP));
  localparam logic [RES_W-1:0] FOLD_D  = 30'((64'd1 << 60) % 64'(MODP));

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BIN = 3'd4;

  // multiplier operand selects; each implies its destination register
  localparam logic [SEL_W-1:0] MS_AB        = 3'd0;  // -> res
  localparam logic [SEL_W-1:0] MS_NUM_FN    = 3'd1;  // -> num
  localparam logic [SEL_W-1:0] MS_DEN_DN    = 3'd2;  // -> den
  localparam logic [SEL_W-1:0] MS_ACC_BASE  = 3'd3;  // -> acc
  localparam logic [SEL_W-1:0] MS_BASE_BASE = 3'd4;  // -> base
  localparam logic [SEL_W-1:0] MS_NUM_ACC   = 3'd5;  // -> res
  localparam logic [SEL_W-1:0] MS_RED_A     = 3'd6;  // -> ra
  localparam logic [SEL_W-1:0] MS_RED_B     = 3'd7;  // -> rb

  typedef struct packed {
    logic             load;
    logic             simple;
    logic             div_init;
    logic             bin_init;
    logic             bin_step;
    logic             fin_init;
    logic             exp_next;
    logic             mul_go;
    logic [SEL_W-1:0] mul_sel;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              too_large;
    logic              k_gt_n;
    logic              exp_bit;
    logic              exp_last;
    logic              dn_zero;
    logic              mul_done;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/mab_mulmod.sv
// ----------------------------------------------------------------------------
// mab_mulmod
// Five-stage pipelined modular multiplier, Barrett reduction by MODP.
// ----------------------------------------------------------------------------
`default_nettype none

module mab_mulmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [mab_pkg::RES_W-1:0]  x,
  input  logic [mab_pkg::RES_W-1:0]  y,
  input  logic [mab_pkg::ADD_W-1:0]  addend,
  output logic                       valid,
  output logic [mab_pkg::RES_W-1:0]  z
);
  import mab_pkg::*;

  logic [4:0]  v;
  logic [59:0] prod1;
  logic [59:0] prod2;
  logic [61:0] t2;
  logic [31:0] lo3;
  logic [31:0] m3;
  logic [31:0] r4;
  logic [RES_W-1:0] z5;

  logic [30:0] q3_in;
  logic [60:0] qp;

  assign q3_in = t2[61:31];
  assign qp    = 61'(q3_in) * 61'(MODP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], go};
    end
  end

  always_ff @(posedge clk) begin
    // x*y + addend stays below 2^60 for every caller
    prod1 <= 60'(x) * 60'(y) + 60'(addend);
    prod2 <= prod1;
    t2    <= 62'(prod1[59:29]) * 62'(MU);
    lo3   <= prod2[31:0];
    m3    <= qp[31:0];
    // true remainder is below 3*MODP, so 32 bits suffice
    r4    <= lo3 - m3;
    if (r4 >= MODP_X2) begin
      z5 <= RES_W'(r4 - MODP_X2);
    end else if (r4 >= 32'(MODP)) begin
      z5 <= RES_W'(r4 - 32'(MODP));
    end else begin
      z5 <= r4[RES_W-1:0];
    end
  end

  assign valid = v[4];
  assign z     = z5;

endmodule

`default_nettype wire

### rtl/core/mab_datapath.sv
// ----------------------------------------------------------------------------
// mab_datapath
// Operand registers, operand folding, binomial counters, exponent
// walk and the shared modular multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module mab_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  mab_pkg::cmd_t               cmd,
  output mab_pkg::status_t            st,
  input  logic [mab_pkg::KIND_W-1:0]  kind,
  input  logic [mab_pkg::OPND_W-1:0]  operand_a,
  input  logic [mab_pkg::OPND_W-1:0]  operand_b,
  output logic [mab_pkg::RES_W-1:0]   residue,
  output logic                        count_too_large
);
  import mab_pkg::*;

  logic [KIND_W-1:0] kind_q;
  logic [OPND_W-1:0] a_raw;
  logic [OPND_W-1:0] b_raw;
  logic [RES_W-1:0]  ra;
  logic [RES_W-1:0]  rb;
  logic [RES_W-1:0]  num;
  logic [RES_W-1:0]  den;
  logic [RES_W-1:0]  acc;
  logic [RES_W-1:0]  base;
  logic [RES_W-1:0]  fn;
  logic [K_W-1:0]    dn;
  logic [4:0]        exp_idx;
  logic [SEL_W-1:0]  sel_q;
  logic [RES_W-1:0]  res;
  logic              big;

  logic [ADD_W-1:0]  fold_a;
  logic [ADD_W-1:0]  fold_b;
  logic [RES_W:0]    sum;
  logic [RES_W-1:0]  simple_res;
  logic [RES_W-1:0]  mx;
  logic [RES_W-1:0]  my;
  logic [ADD_W-1:0]  madd;
  logic              mvalid;
  logic [RES_W-1:0]  mz;
  logic              too_large;

  // operand = hi*2^60 + mid*2^30 + lo; the multiplier forms mid*C + (hi*D + lo)
  assign fold_a = ADD_W'(a_raw[62:60]) * ADD_W'(FOLD_D) + ADD_W'(a_raw[29:0]);
  assign fold_b = ADD_W'(b_raw[62:60]) * ADD_W'(FOLD_D) + ADD_W'(b_raw[29:0]);

  assign sum       = {1'b0, ra} + {1'b0, rb};
  assign too_large = b_raw > OPND_W'(MAX_K);

  always_comb begin
    case (kind_q)
      KIND_ADD: simple_res = (sum >= {1'b0, MODP}) ? RES_W'(sum - {1'b0, MODP})
                                                   : sum[RES_W-1:0];
      KIND_SUB: simple_res = (ra >= rb) ? RES_W'(ra - rb)
                                        : RES_W'({1'b0, ra} + {1'b0, MODP} - {1'b0, rb});
      default:  simple_res = '0;
    endcase
  end

  always_comb begin
    madd = '0;
    case (cmd.mul_sel)
      MS_AB:        begin mx = ra;   my = rb;          end
      MS_NUM_FN:    begin mx = num;  my = fn;          end
      MS_DEN_DN:    begin mx = den;  my = RES_W'(dn);  end
      MS_ACC_BASE:  begin mx = acc;  my = base;        end
      MS_BASE_BASE: begin mx = base; my = base;        end
      MS_NUM_ACC:   begin mx = num;  my = acc;         end
      MS_RED_A:     begin mx = a_raw[59:30]; my = FOLD_C; madd = fold_a; end
      MS_RED_B:     begin mx = b_raw[59:30]; my = FOLD_C; madd = fold_b; end
      default:      begin mx = '0;   my = '0;          end
    endcase
  end

  mab_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .go     (cmd.mul_go),
    .x      (mx),
    .y      (my),
    .addend (madd),
    .valid  (mvalid),
    .z      (mz)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      a_raw   <= operand_a;
      b_raw   <= operand_b;
      big     <= 1'b0;
    end
    if (cmd.simple) begin
      res <= simple_res;
      big <= (kind_q == KIND_BIN) && too_large;
    end
    if (cmd.div_init) begin
      num     <= ra;
      base    <= rb;
      acc     <= RES_W'(1);
      exp_idx <= '0;
    end
    if (cmd.bin_init) begin
      num <= RES_W'(1);
      den <= RES_W'(1);
      fn  <= ra;
      dn  <= b_raw[K_W-1:0];
    end
    if (cmd.bin_step) begin
      fn <= (fn == '0) ? MODP - RES_W'(1) : fn - RES_W'(1);
      dn <= dn - K_W'(1);
    end
    if (cmd.fin_init) begin
      base    <= den;
      acc     <= RES_W'(1);
      exp_idx <= '0;
    end
    if (cmd.exp_next) begin
      exp_idx <= exp_idx + 5'd1;
    end
    if (cmd.mul_go) begin
      sel_q <= cmd.mul_sel;
    end
    if (mvalid) begin
      case (sel_q)
        MS_AB:        res  <= mz;
        MS_NUM_FN:    num  <= mz;
        MS_DEN_DN:    den  <= mz;
        MS_ACC_BASE:  acc  <= mz;
        MS_BASE_BASE: base <= mz;
        MS_NUM_ACC:   res  <= mz;
        MS_RED_A:     ra   <= mz;
        MS_RED_B:     rb   <= mz;
        default:      res  <= mz;
      endcase
    end
  end

  always_comb begin
    st.kind      = kind_q;
    st.too_large = too_large;
    st.k_gt_n    = b_raw > a_raw;
    st.exp_bit   = EXP_E[exp_idx];
    st.exp_last  = (exp_idx == 5'(RES_W - 1));
    st.dn_zero   = (dn == '0);
    st.mul_done  = mvalid;
  end

  assign residue         = res;
  assign count_too_large = big;

endmodule

`default_nettype wire

### rtl/core/mab_ctrl.sv
// ----------------------------------------------------------------------------
// mab_ctrl
// Sequencer: operand reduction, dispatch, binomial loop, Fermat inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module mab_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mab_pkg::status_t  st,
  output mab_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);
  import mab_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RED      = 4'd1;
  localparam logic [3:0] S_DISP     = 4'd2;
  localparam logic [3:0] S_BIN_LOOP = 4'd3;
  localparam logic [3:0] S_BIN_NUM  = 4'd4;
  localparam logic [3:0] S_BIN_DEN  = 4'd5;
  localparam logic [3:0] S_EXP_BIT  = 4'd6;
  localparam logic [3:0] S_EXP_ACC  = 4'd7;
  localparam logic [3:0] S_EXP_SQ   = 4'd8;
  localparam logic [3:0] S_MUL_W    = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;
  localparam logic [3:0] S_RED_A    = 4'd11;
  localparam logic [3:0] S_RED_B    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RED;
        end
      end
      S_RED: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MS_RED_A;
        state_next  = S_RED_A;
      end
      S_RED_A: begin
        if (st.mul_done) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_RED_B;
          state_next  = S_RED_B;
        end
      end
      S_RED_B: begin
        if (st.mul_done) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.kind)
          KIND_MUL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MS_AB;
            state_next  = S_MUL_W;
          end
          KIND_DIV: begin
            cmd.div_init = 1'b1;
            state_next   = S_EXP_BIT;
          end
          KIND_BIN: begin
            if (st.too_large || st.k_gt_n) begin
              cmd.simple = 1'b1;
              state_next = S_OUT;
            end else begin
              cmd.bin_init = 1'b1;
              state_next   = S_BIN_LOOP;
            end
          end
          default: begin
            cmd.simple = 1'b1;
            state_next = S_OUT;
          end
        endcase
      end
      S_BIN_LOOP: begin
        if (st.dn_zero) begin
          cmd.fin_init = 1'b1;
          state_next   = S_EXP_BIT;
        end else begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_NUM_FN;
          state_next  = S_BIN_NUM;
        end
      end
      S_BIN_NUM: begin
        if (st.mul_done) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_DEN_DN;
          state_next  = S_BIN_DEN;
        end
      end
      S_BIN_DEN: begin
        if (st.mul_done) begin
          cmd.bin_step = 1'b1;
          state_next   = S_BIN_LOOP;
        end
      end
      S_EXP_BIT: begin
        cmd.mul_go = 1'b1;
        if (st.exp_bit) begin
          cmd.mul_sel = MS_ACC_BASE;
          state_next  = S_EXP_ACC;
        end else begin
          cmd.mul_sel = MS_BASE_BASE;
          state_next  = S_EXP_SQ;
        end
      end
      S_EXP_ACC: begin
        if (st.mul_done) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MS_BASE_BASE;
          state_next  = S_EXP_SQ;
        end
      end
      S_EXP_SQ: begin
        if (st.mul_done) begin
          if (st.exp_last) begin
            // inverse is in acc; fold in the dividend / numerator
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = MS_NUM_ACC;
            state_next  = S_MUL_W;
          end else begin
            cmd.exp_next = 1'b1;
            state_next   = S_EXP_BIT;
          end
        end
      end
      S_MUL_W: begin
        if (st.mul_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

`default_nettype wire

### rtl/core/modular_arithmetic_binomial_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_binomial_unit
// Add, subtract, multiply, divide and binomial coefficient modulo 1000000007.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind, operand_a and operand_b and raise start; the transfer happens
//   at the clock edge where start is high and busy is low. busy then stays
//   high until the result is out. One item is processed at a time; the next
//   transfer can come once busy is low again, after the done cycle.
//   The result shows on residue and count_too_large, marked by done for one
//   cycle; the receiver must take it then, there is no back-pressure.
//   Both operands are folded through the shared 5-stage modular multiplier,
//   one after the other, before dispatch.
//   Multiplier work per kind after the operands are folded:
//     add, subtract, unused kinds, rejected binomial: no multiply
//     multiply:  one multiply
//     divide:    30 exponent bits, 15 of them set, 46 multiplies
//     binomial:  two multiplies per factor, then one Fermat inversion
//   Divisor 0 gives residue 0. Binomial with k above n gives 0; with k above
//   65536 gives 0 and sets count_too_large.
//   Synchronous reset returns the sequencer to idle and drops busy and done;
//   result fields hold arbitrary values until the first done.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_arithmetic_binomial_unit_macros.svh"

module modular_arithmetic_binomial_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mab_pkg::KIND_W-1:0]  kind,
  input  logic [mab_pkg::OPND_W-1:0]  operand_a,
  input  logic [mab_pkg::OPND_W-1:0]  operand_b,
  output logic                        done,
  output logic [mab_pkg::RES_W-1:0]   residue,
  output logic                        count_too_large
);
  import mab_pkg::*;

  cmd_t    cmd;
  status_t st;

  mab_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  mab_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .kind            (kind),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .residue         (residue),
    .count_too_large (count_too_large)
  );

  `MAB_ASSERT(a_res_range, clk, rst, done |-> (residue < MODP), "residue not reduced")
  `MAB_ASSERT(a_big_zero, clk, rst, (done && count_too_large) |-> (residue == '0), "flag with nonzero residue")
  `MAB_ASSERT(a_done_idle, clk, rst, done |=> !busy, "still busy after done")
  `MAB_ASSERT(a_accept, clk, rst, (start && !busy) |=> (busy && !done), "transfer did not start work")
  `MAB_ASSERT_NEVER(a_done_busy, clk, rst, done && !busy, "done while idle")

endmodule

`default_nettype wire
